// File: rtl/s5scan_pkg.sv
`timescale 1ns / 1ps

package s5scan_pkg;

	// Parsing steps. The order matters: every step from PH_AVAL upward
	// comes after the first value tag.
	typedef enum logic [3:0] {
		PH_SEARCH   = 4'd0,
		PH_AFTERSIG = 4'd1,
		PH_PKGLEN   = 4'd2,
		PH_TAG      = 4'd3,
		PH_AVAL     = 4'd4,
		PH_ATAG2    = 4'd5,
		PH_BVAL     = 4'd6,
		PH_DONE     = 4'd7,
		PH_ZTAG2    = 4'd8
	} phase_t;

	localparam logic [23:0] SIG_HEAD     = 24'h5F5335; // "_S5"
	localparam logic [7:0]  SIG_TAIL     = 8'h5F;      // "_"
	localparam logic [7:0]  OP_PACKAGE   = 8'h12;
	localparam int unsigned LEN_FLAG_BIT = 6;
	localparam logic [7:0]  TAG_BYTE     = 8'h0A;
	localparam logic [7:0]  TAG_ZERO     = 8'h00;
	localparam logic [1:0]  COUNT_FULL   = 2'd2;

	typedef struct packed {
		logic [23:0] recent;
		phase_t      phase;
		logic [1:0]  count;
		logic [15:0] val_a;
		logic [15:0] val_b;
		logic        ok;
	} scan_state_t;

	localparam scan_state_t STATE_RESET = '{
		recent: 24'd0,
		phase:  PH_SEARCH,
		count:  2'd0,
		val_a:  16'd0,
		val_b:  16'd0,
		ok:     1'b0
	};

	function automatic logic [15:0] shift_value(input logic [7:0] b);
		return {b[5:0], 10'd0};
	endfunction

endpackage

// File: rtl/s5scan_step.sv
`timescale 1ns / 1ps

module s5scan_step
	import s5scan_pkg::*;
(
	input  scan_state_t cur,
	input  logic [7:0]  aml_byte,
	output scan_state_t nxt
);

	always_comb begin
		nxt = cur;

		// Count bytes that follow the first value tag, saturating at two.
		if (cur.phase >= PH_AVAL && cur.count < COUNT_FULL) begin
			nxt.count = cur.count + 2'd1;
			if (cur.count == 2'd1) begin
				nxt.ok = 1'b1;
			end
		end

		case (cur.phase)
			PH_SEARCH: begin
				if (cur.recent == SIG_HEAD && aml_byte == SIG_TAIL) begin
					nxt.phase = PH_AFTERSIG;
				end
				nxt.recent = {cur.recent[15:0], aml_byte};
			end
			PH_AFTERSIG: begin
				if (aml_byte == OP_PACKAGE || aml_byte[LEN_FLAG_BIT]) begin
					nxt.phase = PH_PKGLEN;
				end else begin
					nxt.phase = PH_TAG;
				end
			end
			PH_PKGLEN: begin
				if (!aml_byte[LEN_FLAG_BIT]) begin
					nxt.phase = PH_TAG;
				end
			end
			PH_TAG: begin
				nxt.val_a = 16'd0;
				nxt.val_b = 16'd0;
				if (aml_byte == TAG_BYTE) begin
					nxt.phase = PH_AVAL;
				end else if (aml_byte == TAG_ZERO) begin
					nxt.phase = PH_ZTAG2;
				end else begin
					nxt.phase = PH_DONE;
				end
			end
			PH_AVAL: begin
				nxt.val_a = shift_value(aml_byte);
				nxt.val_b = shift_value(aml_byte);
				nxt.phase = PH_ATAG2;
			end
			PH_ATAG2, PH_ZTAG2: begin
				nxt.val_b = cur.val_a;
				nxt.phase = (aml_byte == TAG_BYTE) ? PH_BVAL : PH_DONE;
			end
			PH_BVAL: begin
				nxt.val_b = shift_value(aml_byte);
				nxt.phase = PH_DONE;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/aml_s5_sleep_type_scan_core.sv
`timescale 1ns / 1ps
// Channel  Direction  Signals                        Contents
// s_axis   in         s_tvalid s_tready s_tdata      tdata[7:0] aml_byte, tlast last_byte
//                     s_tlast
// m_axis   out        m_tvalid m_tready m_tdata      tdata[15:0] sleep_type_a,
//                     m_tuser                        tdata[31:16] sleep_type_b, tuser found
//
// A new byte may be accepted every cycle while the input is not stalled.
// The scan state updates in the accepting cycle and the result of a stream
// is registered in the output stage when its last byte is accepted.
// The input stalls only while a result waits in the output stage and
// m_tready is low. Reset clears the scan state and empties the output stage.

module aml_s5_sleep_type_scan_core
	import s5scan_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] aml_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] sleep_type_a, [31:16] sleep_type_b
	output logic        m_tuser    // [0] found
);

	scan_state_t state_q;
	scan_state_t state_nxt;
	logic        in_fire;

	assign s_tready = !m_tvalid || m_tready;
	assign in_fire  = s_tvalid && s_tready;

	s5scan_step u_step (
		.cur      (state_q),
		.aml_byte (s_tdata),
		.nxt      (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (in_fire) begin
			// Every stream starts from a clean scan state.
			state_q <= s_tlast ? STATE_RESET : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (in_fire && s_tlast) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && s_tlast) begin
			m_tuser <= state_nxt.ok;
			m_tdata <= state_nxt.ok ? {state_nxt.val_b, state_nxt.val_a} : 32'd0;
		end
	end

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 32'd0)
		else $error("failed lookup carries nonzero sleep types");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && s_tlast |=> state_q.phase == PH_SEARCH && state_q.count == 2'd0
			&& !state_q.ok)
		else $error("scan state not cleared after last item");

	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.ok == (state_q.count == COUNT_FULL))
		else $error("decoded flag out of step with byte count");

	a_count_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.count != 2'd0 |-> state_q.phase >= PH_ATAG2)
		else $error("bytes counted before first value tag");

	a_found_vals: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[9:0] == 10'd0 && m_tdata[25:16] == 10'd0)
		else $error("sleep type has low bits set");

endmodule

// File: verif/s5_scan_checker.sv
`timescale 1ns / 1ps

module s5_scan_checker
	import s5scan_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] aml_byte
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [15:0] sleep_type_a, [31:16] sleep_type_b
	input  logic        m_tuser,   // [0] found
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic        found;
		logic [15:0] type_a;
		logic [15:0] type_b;
	} sleep_result_t;

	sleep_result_t sleep_type_q[$];

	// Scan state of the predicted block.
	logic [23:0] window;
	phase_t      phase;
	logic [1:0]  tail_cnt;
	logic [15:0] typ_a;
	logic [15:0] typ_b;
	logic        got_two;

	task automatic clear_scan();
		window   = '0;
		phase    = PH_SEARCH;
		tail_cnt = '0;
		typ_a    = '0;
		typ_b    = '0;
		got_two  = 1'b0;
	endtask

	task automatic scan_aml_byte(input logic [7:0] b, input logic last);
		sleep_result_t r;
		// Every byte after the first value tag counts, up to two.
		if (phase >= PH_AVAL && tail_cnt < COUNT_FULL) begin
			tail_cnt = tail_cnt + 2'd1;
			if (tail_cnt == COUNT_FULL)
				got_two = 1'b1;
		end
		case (phase)
			PH_SEARCH: begin
				if (window == SIG_HEAD && b == SIG_TAIL)
					phase = PH_AFTERSIG;
				window = {window[15:0], b};
			end
			PH_AFTERSIG: begin
				if (b == OP_PACKAGE || b[LEN_FLAG_BIT])
					phase = PH_PKGLEN;
				else
					phase = PH_TAG;
			end
			PH_PKGLEN: begin
				if (!b[LEN_FLAG_BIT])
					phase = PH_TAG;
			end
			PH_TAG: begin
				typ_a = '0;
				typ_b = '0;
				if (b == TAG_BYTE)
					phase = PH_AVAL;
				else if (b == TAG_ZERO)
					phase = PH_ZTAG2;
				else
					phase = PH_DONE;
			end
			PH_AVAL: begin
				typ_a = {b[5:0], 10'd0};
				typ_b = typ_a;
				phase = PH_ATAG2;
			end
			PH_ATAG2, PH_ZTAG2: begin
				typ_b = typ_a;
				phase = (b == TAG_BYTE) ? PH_BVAL : PH_DONE;
			end
			PH_BVAL: begin
				typ_b = {b[5:0], 10'd0};
				phase = PH_DONE;
			end
			default: begin
			end
		endcase
		if (last) begin
			r.found  = got_two;
			r.type_a = got_two ? typ_a : 16'd0;
			r.type_b = got_two ? typ_b : 16'd0;
			sleep_type_q.push_back(r);
			clear_scan();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sleep_result_t want;
		if (!arst_n) begin
			clear_scan();
			sleep_type_q.delete();
			pending = 0;
			errors  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (sleep_type_q.size() == 0) begin
					$display("%0t: unexpected result: found=%0b a=%h b=%h", $time,
						m_tuser, m_tdata[15:0], m_tdata[31:16]);
					errors = errors + 1;
				end else begin
					want = sleep_type_q.pop_front();
					if (want.found !== m_tuser || want.type_a !== m_tdata[15:0] ||
							want.type_b !== m_tdata[31:16]) begin
						$display("%0t: mismatch: expected found=%0b a=%h b=%h, got found=%0b a=%h b=%h",
							$time, want.found, want.type_a, want.type_b,
							m_tuser, m_tdata[15:0], m_tdata[31:16]);
						errors = errors + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				scan_aml_byte(s_tdata, s_tlast);
			pending = sleep_type_q.size();
		end
	end

endmodule

// File: verif/tb_aml_s5_sleep_type_scan_core.sv
`timescale 1ns / 1ps

module tb_aml_s5_sleep_type_scan_core;
	import s5scan_pkg::*;

	localparam int BYTE_TARGET = 1400;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] aml_byte
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [15:0] sleep_type_a, [31:16] sleep_type_b
	logic        m_tuser;   // [0] found

	int errors;
	int pending;
	int sent_bytes;
	int cycle_count;
	bit no_gaps;
	bit drained_once;

	logic [7:0] stream_q[$];

	aml_s5_sleep_type_scan_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	s5_scan_checker sleep_type_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Random byte that often hits the signature characters.
	function automatic logic [7:0] rnd_byte();
		case ($urandom_range(0, 7))
			0: return SIG_TAIL;
			1: return SIG_HEAD[15:8];
			2: return SIG_HEAD[7:0];
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_signature();
		stream_q.push_back(SIG_HEAD[23:16]);
		stream_q.push_back(SIG_HEAD[15:8]);
		stream_q.push_back(SIG_HEAD[7:0]);
		stream_q.push_back(SIG_TAIL);
	endtask

	// A package with random content, sometimes cut short at a random point.
	task automatic build_package_stream();
		int n;
		int r;
		int keep;
		stream_q.delete();
		n = $urandom_range(0, 5);
		repeat (n) stream_q.push_back(rnd_byte());
		push_signature();
		if ($urandom_range(0, 9) < 7) begin
			stream_q.push_back(OP_PACKAGE);
			n = $urandom_range(0, 2);
			repeat (n) stream_q.push_back(8'($urandom_range(0, 255)) | 8'h40);
			stream_q.push_back(8'($urandom_range(0, 255)) & 8'hBF);
		end else begin
			stream_q.push_back(8'($urandom_range(0, 255)));
		end
		r = $urandom_range(0, 9);
		if (r < 6)
			stream_q.push_back(TAG_BYTE);
		else if (r < 8)
			stream_q.push_back(TAG_ZERO);
		else
			stream_q.push_back(8'($urandom_range(0, 255)));
		stream_q.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) < 7)
			stream_q.push_back(TAG_BYTE);
		else
			stream_q.push_back(8'($urandom_range(0, 255)));
		stream_q.push_back(8'($urandom_range(0, 255)));
		n = $urandom_range(0, 3);
		repeat (n) stream_q.push_back(rnd_byte());
		if ($urandom_range(0, 4) == 0) begin
			keep = $urandom_range(1, stream_q.size());
			while (stream_q.size() > keep)
				void'(stream_q.pop_back());
		end
	endtask

	task automatic send_stream();
		int gap;
		for (int i = 0; i < stream_q.size(); i++) begin
			gap = no_gaps ? 0 : pick_gap();
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= stream_q[i];
			s_tlast  <= (i == stream_q.size() - 1);
			do @(posedge clk); while (!s_tready);
			sent_bytes = sent_bytes + 1;
		end
	endtask

	task automatic send_fixed(input logic [7:0] bytes[$]);
		stream_q = bytes;
		send_stream();
	endtask

	// Receiver side, with one long hold-off once traffic is under way.
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && sent_bytes > 300) begin
				m_tready <= 1'b0;
				repeat (80) @(posedge clk);
				held = 1'b1;
			end else if ($urandom_range(0, 19) == 0) begin
				m_tready <= 1'b1;
				repeat (25) @(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int n;
		arst_n       <= 1'b0;
		s_tvalid     <= 1'b0;
		s_tdata      <= '0;
		s_tlast      <= 1'b0;
		cycle_count  = 0;
		sent_bytes   = 0;
		no_gaps      = 1'b0;
		drained_once = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No signature at all.
		send_fixed('{8'hFF});
		// Full package with length bytes and extreme values.
		send_fixed('{8'h5F, 8'h53, 8'h35, 8'h5F, 8'h12, 8'h7F, 8'h02,
			8'h0A, 8'hFF, 8'h0A, 8'h3F});
		// Zero first tag and zero second tag; the final tag byte comes after the scan is done.
		send_fixed('{8'h5F, 8'h53, 8'h35, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h0A});
		// Stream ends before the first tag is reached.
		send_fixed('{8'h5F, 8'h53, 8'h35, 8'h5F, 8'h40, 8'h05});

		while (sent_bytes < BYTE_TARGET) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if (!drained_once && sent_bytes > BYTE_TARGET / 2) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pending != 0);
				drained_once = 1'b1;
			end
			if ($urandom_range(0, 3) == 0) begin
				stream_q.delete();
				n = $urandom_range(1, 12);
				repeat (n) stream_q.push_back(rnd_byte());
			end else begin
				build_package_stream();
			end
			send_stream();
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
